// File: rtl/text_console_writer_assert.svh
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// Types and constants shared by the text console writer modules.
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int NUM_COLS = 80;
   localparam int NUM_ROWS = 25;
   localparam int CELLS = NUM_ROWS * NUM_COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W = 5;
   localparam int COL_W = 7;
   localparam int CELL_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_RETURN = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] TEXT_ATTR_RESET = 8'h0c;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(NUM_COLS);
   localparam logic [ADDR_W-1:0] BLANK_LAST = ADDR_W'(NUM_COLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((NUM_ROWS - 1) * NUM_COLS);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_CLEAR,
      CMD_READ,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0] char_code;
      logic [ADDR_W-1:0] read_addr;
   } cmd_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } back_ctrl_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK,
      ST_FILL
   } state_type;

endpackage

// File: rtl/tcw_if.sv
// Channel interfaces of the text console writer: request, response and register write.
`timescale 1ns / 1ps
interface tcw_req_if;
   import tcw_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] req_type;
   logic [7:0] char_code;
   logic [ROW_W-1:0] read_row;
   logic [COL_W-1:0] read_col;
   modport source (output valid, req_type, char_code, read_row, read_col, input ready);
   modport sink (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic valid;
   logic ready;
   logic [ROW_W-1:0] cursor_row;
   logic [COL_W-1:0] cursor_col;
   logic [7:0] read_char;
   logic [7:0] read_attr;
   logic scrolled;
   modport source (output valid, cursor_row, cursor_col, read_char, read_attr, scrolled,
                   input ready);
   modport sink (input valid, cursor_row, cursor_col, read_char, read_attr, scrolled,
                 output ready);
endinterface

interface tcw_csr_if;
   logic valid;
   logic ready;
   logic [7:0] text_attr;
   modport source (output valid, text_attr, input ready);
   modport sink (input valid, text_attr, output ready);
endinterface

// File: rtl/text_console_writer.sv
// Top level of the text console writer: request front end, command back end and checks.
//
// Requests arrive on req_bus (write character, clear screen, read one cell) and each
// produces exactly one response transaction on rsp_bus with the cursor after the
// request, the cell read and a scroll flag. csr_bus writes the text attribute byte;
// it is always ready and should be written only while no request is in flight.
// A two-entry command queue sits between the front end and the back end.
// A plain character, newline without scroll or unused request is answered through the
// queue entry and the response register; a cell read also passes through ST_READ for
// the store's registered read data. Plain characters sustain one transaction per cycle
// while rsp_bus is ready and no scroll runs; the next command after a read waits until
// ST_READ is left. A scroll moves every cell up one row through the single read and
// write port, one cell per cycle (ST_COPY), then blanks the bottom row (ST_BLANK). A
// clear fills one cell per cycle. After reset the store is filled the same way, with
// attribute 12 plus each cell's row and column; req_bus.ready stays low until that
// fill is done, while csr_bus writes are still taken. When rsp_bus stalls, the response
// register holds and the queue takes up to two more requests before req_bus.ready drops.
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"
module text_console_writer (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_bus,
   tcw_rsp_if.source rsp_bus,
   tcw_csr_if.sink   csr_bus
);
   import tcw_pkg::*;

   queue_head_type head;
   back_ctrl_type  back_ctrl;

   tcw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .back_ctrl(back_ctrl),
      .head     (head)
   );

   tcw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_bus),
      .rsp      (rsp_bus),
      .head     (head),
      .back_ctrl(back_ctrl)
   );

   `TCW_ASSERT_SAME(a_no_accept_in_init, clock, reset, !back_ctrl.init_done, !req_bus.ready, "request ready during initial fill")
   `TCW_ASSERT_SAME(a_cursor_in_range, clock, reset, rsp_bus.valid, (rsp_bus.cursor_row <= ROW_LAST) && (rsp_bus.cursor_col <= COL_LAST), "cursor out of range")
   `TCW_ASSERT_SAME(a_scroll_at_bottom, clock, reset, rsp_bus.valid && rsp_bus.scrolled, (rsp_bus.cursor_row == ROW_LAST) && (rsp_bus.cursor_col == '0), "scroll without bottom cursor")
   `TCW_ASSERT_NEXT(a_report_answers, clock, reset, back_ctrl.pop && head.cmd.kind == CMD_REPORT, rsp_bus.valid, "report command gave no response")
endmodule

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/tcw_front.sv
// Request front end: classifies requests and holds them in a short command queue.
`timescale 1ns / 1ps
module tcw_front (
   input  logic                    clock,
   input  logic                    reset,
   tcw_req_if.sink                 req,
   input  tcw_pkg::back_ctrl_type  back_ctrl,
   output tcw_pkg::queue_head_type head
);
   import tcw_pkg::*;

   cmd_type                 cmd;
   logic                    in_range;
   logic                    push;
   logic                    pop;
   cmd_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff;
   logic [QUEUE_CNT_W-1:0]  count_in;

   always_comb begin
      in_range = (32'(req.read_row) < NUM_ROWS) && (32'(req.read_col) < NUM_COLS);
      cmd.char_code = req.char_code;
      cmd.read_addr = ADDR_W'(32'(req.read_row) * NUM_COLS + 32'(req.read_col));
      case (req.req_type)
         REQ_WRITE: begin
            if (req.char_code == CH_NEWLINE || req.char_code == CH_RETURN) begin
               cmd.kind = CMD_NEWLINE;
            end else begin
               cmd.kind = CMD_PUT;
            end
         end
         REQ_CLEAR: cmd.kind = CMD_CLEAR;
         REQ_READ: cmd.kind = in_range ? CMD_READ : CMD_REPORT;
         default: cmd.kind = CMD_REPORT;
      endcase
   end

   assign req.ready = back_ctrl.init_done && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push = req.valid && req.ready;
   assign pop = back_ctrl.pop && head.valid;
   assign head.valid = (count_ff != '0);
   assign head.cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule

// File: rtl/tcw_back.sv
// Command back end: cursor, screen store sequencer and response register.
`timescale 1ns / 1ps
module tcw_back (
   input  logic                    clock,
   input  logic                    reset,
   tcw_csr_if.sink                 csr,
   tcw_rsp_if.source               rsp,
   input  tcw_pkg::queue_head_type head,
   output tcw_pkg::back_ctrl_type  back_ctrl
);
   import tcw_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0]  cnt_in;
   logic [ROW_W-1:0]   fill_row_ff;
   logic [ROW_W-1:0]   fill_row_in;
   logic [COL_W-1:0]   fill_col_ff;
   logic [COL_W-1:0]   fill_col_in;
   logic [ROW_W-1:0]   cur_row_ff;
   logic [ROW_W-1:0]   cur_row_in;
   logic [COL_W-1:0]   cur_col_ff;
   logic [COL_W-1:0]   cur_col_in;
   logic [ADDR_W-1:0]  cur_base_ff;
   logic [ADDR_W-1:0]  cur_base_in;
   logic [7:0]         attr_ff;
   logic [7:0]         attr_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [7:0]         rsp_char_ff;
   logic [7:0]         rsp_attr_ff;
   logic               rsp_scr_ff;
   logic               load;
   logic [7:0]         res_char;
   logic [7:0]         res_attr;
   logic               res_scr;
   logic               slot_free;
   logic               pop;
   logic               fill_last;
   logic               row_last;
   logic               col_last;
   logic               line_break;
   logic [7:0]         fill_base;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [CELL_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [CELL_W-1:0]  ram_rd_data;

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELLS)
   ) u_screen (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign pop = (state_ff == ST_IDLE) && head.valid && slot_free;
   assign fill_last = (cnt_ff == CELL_LAST);
   assign row_last = (cur_row_ff == ROW_LAST);
   assign col_last = (cur_col_ff == COL_LAST);
   assign line_break = pop && ((head.cmd.kind == CMD_PUT && col_last) ||
                               head.cmd.kind == CMD_NEWLINE);
   assign fill_base = (state_ff == ST_INIT) ? TEXT_ATTR_RESET : attr_ff;

   assign back_ctrl.pop = pop;
   assign back_ctrl.init_done = (state_ff != ST_INIT);
   assign csr.ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pop) begin
               case (head.cmd.kind)
                  CMD_PUT: if (col_last && row_last) state_in = ST_COPY;
                  CMD_NEWLINE: if (row_last) state_in = ST_COPY;
                  CMD_CLEAR: state_in = ST_FILL;
                  CMD_READ: state_in = ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_COPY: begin
            if (cnt_ff == BOTTOM_BASE) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (cnt_ff == BLANK_LAST) state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (fill_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      fill_row_in = fill_row_ff;
      fill_col_in = fill_col_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      cur_base_in = cur_base_ff;
      attr_in = csr.valid ? csr.text_attr : attr_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = cnt_ff;
      ram_wr_data = '0;
      ram_rd_en = 1'b0;
      ram_rd_addr = head.cmd.read_addr;
      load = 1'b0;
      res_char = '0;
      res_attr = '0;
      res_scr = 1'b0;
      case (state_ff)
         ST_INIT, ST_FILL: begin
            ram_wr_en = 1'b1;
            ram_wr_data = {fill_base + 8'(fill_row_ff) + 8'(fill_col_ff), CH_SPACE};
            if (fill_last) begin
               cnt_in = '0;
               fill_row_in = '0;
               fill_col_in = '0;
               load = (state_ff == ST_FILL);
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (fill_col_ff == COL_LAST) begin
                  fill_col_in = '0;
                  fill_row_in = fill_row_ff + 1'b1;
               end else begin
                  fill_col_in = fill_col_ff + 1'b1;
               end
            end
         end
         ST_IDLE: begin
            if (pop) begin
               case (head.cmd.kind)
                  CMD_PUT: begin
                     ram_wr_en = 1'b1;
                     ram_wr_addr = cur_base_ff + ADDR_W'(cur_col_ff);
                     ram_wr_data = {attr_ff, head.cmd.char_code};
                     if (!col_last) begin
                        cur_col_in = cur_col_ff + 1'b1;
                        load = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in = '0;
                     cur_row_in = '0;
                     cur_col_in = '0;
                     cur_base_in = '0;
                  end
                  CMD_READ: ram_rd_en = 1'b1;
                  CMD_REPORT: load = 1'b1;
                  default: load = 1'b0;
               endcase
               if (line_break) begin
                  cur_col_in = '0;
                  cnt_in = '0;
                  if (!row_last) begin
                     cur_row_in = cur_row_ff + 1'b1;
                     cur_base_in = cur_base_ff + ROW_STEP;
                     load = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            load = 1'b1;
            res_char = ram_rd_data[7:0];
            res_attr = ram_rd_data[15:8];
         end
         ST_COPY: begin
            if (cnt_ff != BOTTOM_BASE) begin
               ram_rd_en = 1'b1;
               ram_rd_addr = cnt_ff + ROW_STEP;
            end
            if (cnt_ff != '0) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = cnt_ff - 1'b1;
               ram_wr_data = ram_rd_data;
            end
            cnt_in = (cnt_ff == BOTTOM_BASE) ? '0 : cnt_ff + 1'b1;
         end
         ST_BLANK: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = BOTTOM_BASE + cnt_ff;
            ram_wr_data = {attr_ff, CH_SPACE};
            if (cnt_ff == BLANK_LAST) begin
               cnt_in = '0;
               load = 1'b1;
               res_scr = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: load = 1'b0;
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff <= '0;
         fill_row_ff <= '0;
         fill_col_ff <= '0;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         cur_base_ff <= '0;
         attr_ff <= TEXT_ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         fill_row_ff <= fill_row_in;
         fill_col_ff <= fill_col_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         cur_base_ff <= cur_base_in;
         attr_ff <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_ff <= cur_row_in;
         rsp_col_ff <= cur_col_in;
         rsp_char_ff <= res_char;
         rsp_attr_ff <= res_attr;
         rsp_scr_ff <= res_scr;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.cursor_row = rsp_row_ff;
   assign rsp.cursor_col = rsp_col_ff;
   assign rsp.read_char = rsp_char_ff;
   assign rsp.read_attr = rsp_attr_ff;
   assign rsp.scrolled = rsp_scr_ff;
endmodule

// File: tb/sv/tb_text_console_writer.sv
// Self-checking testbench of the text console writer: directed table, random traffic, predictor.
`timescale 1ns / 1ps
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 64;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } console_req_type;

   typedef struct packed {
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic [7:0] read_char;
      logic [7:0] read_attr;
      logic scrolled;
   } console_rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic typed;
      logic [ROW_W-1:0] e_row;
      logic [COL_W-1:0] e_col;
      logic [7:0] e_char;
      logic [7:0] e_attr;
      logic e_scr;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{REQ_READ,   8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 8'h20, 8'h0c, 1'b0},
      '{REQ_READ,   8'hff, 5'd24, 7'd79,  1'b1, 5'd0, 7'd0, 8'h20, 8'h73, 1'b0},
      '{REQ_READ,   8'h00, 5'd0,  7'd79,  1'b1, 5'd0, 7'd0, 8'h20, 8'h5b, 1'b0},
      '{REQ_READ,   8'h00, 5'd24, 7'd0,   1'b1, 5'd0, 7'd0, 8'h20, 8'h24, 1'b0},
      '{REQ_READ,   8'h00, 5'd25, 7'd0,   1'b1, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_READ,   8'hff, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_READ,   8'h00, 5'd0,  7'd80,  1'b1, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_UNUSED, 8'hff, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h00, 5'd31, 7'd127, 1'b1, 5'd0, 7'd1, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'hff, 5'd0,  7'd0,   1'b1, 5'd0, 7'd2, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h0a, 5'd17, 7'd42,  1'b1, 5'd1, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h0d, 5'd3,  7'd99,  1'b1, 5'd2, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h09, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h0b, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h0c, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_WRITE,  8'h0e, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_READ,   8'h55, 5'd0,  7'd0,   1'b1, 5'd2, 7'd4, 8'h00, 8'hff, 1'b0},
      '{REQ_READ,   8'haa, 5'd0,  7'd1,   1'b1, 5'd2, 7'd4, 8'hff, 8'hff, 1'b0},
      '{REQ_READ,   8'h00, 5'd2,  7'd3,   1'b0, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_CLEAR,  8'h41, 5'd7,  7'd9,   1'b1, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0},
      '{REQ_READ,   8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 8'h20, 8'hff, 1'b0},
      '{REQ_READ,   8'h00, 5'd0,  7'd1,   1'b1, 5'd0, 7'd0, 8'h20, 8'h00, 1'b0},
      '{REQ_READ,   8'h00, 5'd24, 7'd79,  1'b1, 5'd0, 7'd0, 8'h20, 8'h66, 1'b0},
      '{REQ_WRITE,  8'h7e, 5'd31, 7'd127, 1'b0, 5'd0, 7'd0, 8'h00, 8'h00, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();
   tcw_csr_if csr_if ();

   text_console_writer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   logic [CELL_W-1:0] pred_cells [CELLS];
   logic [ROW_W-1:0] pred_row;
   logic [COL_W-1:0] pred_col;
   logic [7:0] pred_attr;
   console_rsp_type replies_due [$];

   bit offer_typed;
   console_rsp_type offer_typed_rsp;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_left;
   int mismatch_count;
   int cycle_count;
   int random_sent;
   int random_count;
   bit pressure_on;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void fill_screen();
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            pred_cells[r * NUM_COLS + c] = {8'(int'(pred_attr) + r + c), CH_SPACE};
         end
      end
      pred_row = '0;
      pred_col = '0;
   endfunction

   function automatic logic start_line();
      pred_col = '0;
      if (pred_row != ROW_LAST) begin
         pred_row = pred_row + 1'b1;
         return 1'b0;
      end
      for (int i = 0; i < CELLS - NUM_COLS; i++) begin
         pred_cells[i] = pred_cells[i + NUM_COLS];
      end
      for (int i = CELLS - NUM_COLS; i < CELLS; i++) begin
         pred_cells[i] = {pred_attr, CH_SPACE};
      end
      return 1'b1;
   endfunction

   function automatic console_rsp_type predict_console(input console_req_type rq);
      console_rsp_type r;
      logic [CELL_W-1:0] stored;
      r = '0;
      case (rq.kind)
         REQ_WRITE: begin
            if (rq.code != CH_NEWLINE && rq.code != CH_RETURN) begin
               pred_cells[int'(pred_row) * NUM_COLS + int'(pred_col)] = {pred_attr, rq.code};
               if (pred_col == COL_LAST) begin
                  r.scrolled = start_line();
               end else begin
                  pred_col = pred_col + 1'b1;
               end
            end else begin
               r.scrolled = start_line();
            end
         end
         REQ_CLEAR: begin
            fill_screen();
         end
         REQ_READ: begin
            if (int'(rq.row) < NUM_ROWS && int'(rq.col) < NUM_COLS) begin
               stored = pred_cells[int'(rq.row) * NUM_COLS + int'(rq.col)];
               r.read_char = stored[7:0];
               r.read_attr = stored[15:8];
            end
         end
         default: begin
         end
      endcase
      r.cursor_row = pred_row;
      r.cursor_col = pred_col;
      return r;
   endfunction

   always @(posedge clock) begin
      console_rsp_type got;
      console_rsp_type want;
      console_req_type rq;
      if (reset) begin
         pred_attr = TEXT_ATTR_RESET;
         fill_screen();
         replies_due.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.cursor_row = rsp_if.cursor_row;
            got.cursor_col = rsp_if.cursor_col;
            got.read_char = rsp_if.read_char;
            got.read_attr = rsp_if.read_attr;
            got.scrolled = rsp_if.scrolled;
            if (replies_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected response: row %0d col %0d char %02h attr %02h scrolled %0d",
                           got.cursor_row, got.cursor_col, got.read_char, got.read_attr,
                           got.scrolled);
               end
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("response mismatch: expected row %0d col %0d char %02h attr %02h scrolled %0d",
                              want.cursor_row, want.cursor_col, want.read_char, want.read_attr,
                              want.scrolled);
                     $display("                   actual   row %0d col %0d char %02h attr %02h scrolled %0d",
                              got.cursor_row, got.cursor_col, got.read_char, got.read_attr,
                              got.scrolled);
                  end
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            pred_attr = csr_if.text_attr;
         end
         if (req_if.valid && req_if.ready) begin
            rq.kind = req_if.req_type;
            rq.code = req_if.char_code;
            rq.row = req_if.read_row;
            rq.col = req_if.read_col;
            want = predict_console(rq);
            replies_due.push_back(offer_typed ? offer_typed_rsp : want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic offer_request(input console_req_type rq, input bit typed,
                                input console_rsp_type exp_rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= rq.kind;
      req_if.char_code <= rq.code;
      req_if.read_row <= rq.row;
      req_if.read_col <= rq.col;
      offer_typed = typed;
      offer_typed_rsp = exp_rsp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic await_all_replies();
      req_if.valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_text_attr(input logic [7:0] value);
      csr_if.valid <= 1'b1;
      csr_if.text_attr <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic offer_random(input console_req_type rq);
      if (pressure_on && random_sent == 40) begin
         stall_left = HOLD_CYCLES;
      end
      if (pressure_on && random_sent == random_count / 2) begin
         await_all_replies();
      end
      offer_request(rq, 1'b0, '0);
      random_sent++;
   endtask

   task automatic run_random_phase(input int count, input bit with_pressure);
      console_req_type rq;
      int pick;
      int len;
      random_sent = 0;
      random_count = count;
      pressure_on = with_pressure;
      while (random_sent < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = $urandom_range(1, 90);
            for (int i = 0; i < len && random_sent < count; i++) begin
               rq.kind = REQ_WRITE;
               rq.row = ROW_W'($urandom);
               rq.col = COL_W'($urandom);
               if ($urandom_range(7) == 0) begin
                  rq.code = 8'($urandom);
               end else begin
                  rq.code = 8'($urandom_range(32, 126));
               end
               if ($urandom_range(29) == 0) begin
                  rq.code = $urandom_range(1) ? CH_NEWLINE : CH_RETURN;
               end
               offer_random(rq);
            end
         end else if (pick < 55) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len && random_sent < count; i++) begin
               rq.kind = REQ_WRITE;
               rq.code = $urandom_range(1) ? CH_NEWLINE : CH_RETURN;
               rq.row = ROW_W'($urandom);
               rq.col = COL_W'($urandom);
               offer_random(rq);
            end
         end else if (pick < 85) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len && random_sent < count; i++) begin
               rq.kind = REQ_READ;
               rq.code = 8'($urandom);
               case ($urandom_range(3))
                  0: rq.row = pred_row;
                  1: rq.row = ROW_LAST;
                  default: rq.row = ROW_W'($urandom_range(NUM_ROWS - 1));
               endcase
               rq.col = COL_W'($urandom_range(NUM_COLS - 1));
               offer_random(rq);
            end
         end else if (pick < 88) begin
            rq.kind = REQ_CLEAR;
            rq.code = 8'($urandom);
            rq.row = ROW_W'($urandom);
            rq.col = COL_W'($urandom);
            offer_random(rq);
         end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len && random_sent < count; i++) begin
               rq.code = 8'($urandom);
               if ($urandom_range(1)) begin
                  rq.kind = REQ_UNUSED;
                  rq.row = ROW_W'($urandom);
                  rq.col = COL_W'($urandom);
               end else if ($urandom_range(1)) begin
                  rq.kind = REQ_READ;
                  rq.row = ROW_W'($urandom_range(NUM_ROWS, 31));
                  rq.col = COL_W'($urandom);
               end else begin
                  rq.kind = REQ_READ;
                  rq.row = ROW_W'($urandom);
                  rq.col = COL_W'($urandom_range(NUM_COLS, 127));
               end
               offer_random(rq);
            end
         end
      end
   endtask

   initial begin
      console_req_type rq;
      console_rsp_type exp_rsp;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_WRITE;
      req_if.char_code = '0;
      req_if.read_row = '0;
      req_if.read_col = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.text_attr = '0;
      offer_typed = 1'b0;
      offer_typed_rsp = '0;
      send_idle_pct = 36;
      recv_idle_pct = 80;
      stall_left = 0;
      mismatch_count = 0;
      cycle_count = 0;
      random_sent = 0;
      random_count = 0;
      pressure_on = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_text_attr(8'hff);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         rq.kind = DIRECTED[i].kind;
         rq.code = DIRECTED[i].code;
         rq.row = DIRECTED[i].row;
         rq.col = DIRECTED[i].col;
         exp_rsp.cursor_row = DIRECTED[i].e_row;
         exp_rsp.cursor_col = DIRECTED[i].e_col;
         exp_rsp.read_char = DIRECTED[i].e_char;
         exp_rsp.read_attr = DIRECTED[i].e_attr;
         exp_rsp.scrolled = DIRECTED[i].e_scr;
         offer_request(rq, DIRECTED[i].typed, exp_rsp);
      end
      run_random_phase(383, 1'b0);
      await_all_replies();

      write_text_attr(8'h00);
      send_idle_pct = 80;
      recv_idle_pct = 36;
      run_random_phase(383, 1'b0);
      await_all_replies();

      write_text_attr(8'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(384, 1'b1);
      await_all_replies();

      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/sv/tb_text_console_writer.sv
